// ===== hw/rtl/rsf_pkg.sv =====
// Shared types, constants and helpers for the replay sequence filter.
// Used by the slot table, the top level and the port checker; no dependencies.

package rsf_pkg;

   // Table geometry
   localparam int SLOT_COUNT = 8;
   localparam int ID_CHARS   = 8;
   localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   // Field widths
   localparam int ID_W        = 64;
   localparam int SEQ_W       = 32;
   localparam int SLOT_OUT_W  = 3;
   localparam int ACTION_W    = 2;
   localparam int REQ_TDATA_W = 96;
   localparam int RSP_TDATA_W = 8;

   // Outcome of one frame check
   typedef enum logic [ACTION_W-1:0] {
      ACT_CLAIM  = 2'd0,
      ACT_UPDATE = 2'd1,
      ACT_REJECT = 2'd2,
      ACT_EVICT  = 2'd3
   } action_type;

   // Write port of the slot table
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] index;
      logic [ID_W-1:0]   source;
      logic [SEQ_W-1:0]  seq;
   } slot_write_type;

   // Cut the id at its first zero byte and keep at most ID_CHARS characters
   function automatic logic [ID_W-1:0] normalize_id(input logic [ID_W-1:0] raw);
      logic [ID_W-1:0] id;
      logic            keep;
      id   = '0;
      keep = 1'b1;
      for (int i = 0; i < ID_W / 8; i++) begin
         keep = keep & (i < ID_CHARS) & (raw[8*i +: 8] != 8'd0);
         if (keep) begin
            id[8*i +: 8] = raw[8*i +: 8];
         end
      end
      return id;
   endfunction

endpackage

// ===== hw/rtl/rsf_slot_table.sv =====
// Slot table of the replay sequence filter: stored source ids and last sequences.
// One read port addressed by the scan index, one write port. Depends on rsf_pkg.

module rsf_slot_table
   import rsf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [SLOT_W-1:0]    rd_index,
   output logic [ID_W-1:0]      rd_source,
   output logic [SEQ_W-1:0]     rd_seq,
   input  slot_write_type       wr
);

   logic [ID_W-1:0]  source_ff [SLOT_COUNT];
   logic [SEQ_W-1:0] seq_ff    [SLOT_COUNT];

   // Clear the ids at reset so every slot reads as empty
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            source_ff[i] <= '0;
         end
      end else if (wr.en) begin
         source_ff[wr.index] <= wr.source;
      end
   end

   // Sequence is only read behind a non-empty id, so it needs no reset
   always_ff @(posedge clock) begin
      if (wr.en) begin
         seq_ff[wr.index] <= wr.seq;
      end
   end

   assign rd_source = source_ff[rd_index];
   assign rd_seq    = seq_ff[rd_index];

endmodule

// ===== hw/rtl/replay_sequence_filter_core.sv =====
// Replay sequence filter: walks the slot table one slot a cycle with a single
// compare unit and returns one verdict per frame. Depends on rsf_pkg and rsf_slot_table.
//
// A frame visits k slots (1 to SLOT_COUNT) after acceptance; its result is
// registered into the rsp_ output register once the output is free.
// A new frame is taken only after the verdict of the current one is committed.
// Reset: synchronous; empties every slot and drops any pending transaction.

module replay_sequence_filter_core
   import rsf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Input frames
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [63:0] source_id, [95:64] seq_number
   // Verdicts
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // [0] accepted, [2:1] action, [5:3] slot_index
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   localparam int IDX_EXT_W = (SLOT_W > SLOT_OUT_W) ? SLOT_W : SLOT_OUT_W;

   state_type              state_ff, state_in;
   logic [ID_W-1:0]        id_ff, id_in;
   logic [SEQ_W-1:0]       seq_ff, seq_in;
   logic [SLOT_W-1:0]      idx_ff, idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   accepted_ff, accepted_in;
   action_type             action_ff, action_in;
   logic [SLOT_OUT_W-1:0]  slot_ff, slot_in;

   logic [ID_W-1:0]        rd_source;
   logic [SEQ_W-1:0]       rd_seq;
   slot_write_type         wr;

   logic                   slot_empty;
   logic                   slot_hit;
   logic                   seq_newer;
   logic                   last_slot;
   logic                   out_free;
   logic                   decide;
   logic                   commit;
   action_type             verdict;
   logic [SLOT_W-1:0]      target;
   logic [IDX_EXT_W-1:0]   target_ext;

   rsf_slot_table u_table (
      .clock     (clock),
      .reset     (reset),
      .rd_index  (idx_ff),
      .rd_source (rd_source),
      .rd_seq    (rd_seq),
      .wr        (wr)
   );

   // Compare the current slot against the held frame
   assign slot_empty = (rd_source == '0);
   assign slot_hit   = (rd_source == id_ff);
   assign seq_newer  = (seq_ff > rd_seq);
   assign last_slot  = (idx_ff == SLOT_W'(SLOT_COUNT - 1));

   // First empty or matching slot wins; a full table evicts slot 0
   always_comb begin
      if (slot_empty) begin
         verdict = ACT_CLAIM;
      end else if (slot_hit && seq_newer) begin
         verdict = ACT_UPDATE;
      end else if (slot_hit) begin
         verdict = ACT_REJECT;
      end else begin
         verdict = ACT_EVICT;
      end
   end

   assign target     = (verdict == ACT_EVICT) ? '0 : idx_ff;
   assign target_ext = IDX_EXT_W'(target);

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign decide   = (state_ff == ST_SCAN) && (slot_empty || slot_hit || last_slot);
   assign commit   = decide && out_free;

   // Write back only when the verdict is committed and is not a reject
   always_comb begin
      wr.en     = commit && (verdict != ACT_REJECT);
      wr.index  = target;
      wr.source = id_ff;
      wr.seq    = seq_ff;
   end

   // Sequencer and output register
   always_comb begin
      state_in     = state_ff;
      id_in        = id_ff;
      seq_in       = seq_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      accepted_in  = accepted_ff;
      action_in    = action_ff;
      slot_in      = slot_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               id_in    = normalize_id(req_tdata[ID_W-1:0]);
               seq_in   = req_tdata[ID_W +: SEQ_W];
               idx_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (commit) begin
               rsp_valid_in = 1'b1;
               accepted_in  = (verdict != ACT_REJECT);
               action_in    = verdict;
               slot_in      = target_ext[SLOT_OUT_W-1:0];
               state_in     = ST_IDLE;
            end else if (!decide) begin
               idx_in = SLOT_W'(idx_ff + 1'b1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      id_ff       <= id_in;
      seq_ff      <= seq_in;
      idx_ff      <= idx_in;
      accepted_ff <= accepted_in;
      action_ff   <= action_in;
      slot_ff     <= slot_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - SLOT_OUT_W - ACTION_W - 1){1'b0}},
                        slot_ff, action_ff, accepted_ff};

endmodule

// ===== hw/rtl/rsf_port_checker.sv =====
// Port-level checks for the replay sequence filter, bound to its top level.
// Depends on rsf_pkg and replay_sequence_filter_core.

module rsf_port_checker
   import rsf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic       rsp_accepted;
   action_type rsp_action;
   logic [SLOT_OUT_W-1:0] rsp_slot;
   logic       req_take;

   assign rsp_accepted = rsp_tdata[0];
   assign rsp_action   = action_type'(rsp_tdata[ACTION_W:1]);
   assign rsp_slot     = rsp_tdata[ACTION_W + SLOT_OUT_W:ACTION_W + 1];
   assign req_take     = req_tvalid && req_tready;

   // A stalled verdict holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("verdict changed while stalled");

   // Only a replay is refused
   a_accept_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_accepted == (rsp_action != ACT_REJECT)))
      else $error("accepted flag disagrees with action");

   // Eviction always lands in slot 0
   a_evict_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_action == ACT_EVICT) |-> (rsp_slot == '0))
      else $error("eviction reported outside slot 0");

   // One frame in flight: busy for at least the scan cycle after a transaction
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_tready)
      else $error("new frame taken during a scan");

endmodule

bind replay_sequence_filter_core rsf_port_checker u_rsf_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
